// ===== src/afd_pkg.sv =====
// Shared types, constants and predictor table for the frame decoder.
`default_nettype none

package afd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 14;
    localparam int ACC_W    = 33;
    localparam int FRAC_W   = 11;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam acc_t SAT_MAX = acc_t'(32767);
    localparam acc_t SAT_MIN = -acc_t'(32768);

    // frame lengths, header byte included
    localparam logic [3:0] FRAME_LEN_LARGE = 4'd9;
    localparam logic [3:0] FRAME_LEN_SMALL = 4'd5;

    // left shift applied to a code before scaling
    localparam logic [4:0] CODE_K_LARGE = 5'd11;
    localparam logic [4:0] CODE_K_SMALL = 5'd13;

    // index of the final code in a data byte
    localparam logic [1:0] LAST_IDX_LARGE = 2'd1;
    localparam logic [1:0] LAST_IDX_SMALL = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TERM0,
        ST_TERM1
    } state_t;

    // controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic load;      // first pass: code term + prev * c0 into accumulator
        logic older_sel; // second pass operands: older sample and c1
    } mac_ctrl_t;

    typedef struct packed {
        coef_t c0;
        coef_t c1;
    } coef_pair_t;

    function automatic coef_pair_t pred_coef(input logic [3:0] sel);
        coef_pair_t r;
        unique case (sel)
            4'd0:    r = '{c0: coef_t'(0),       c1: coef_t'(0)};
            4'd1:    r = '{c0: coef_t'(16'h0800), c1: coef_t'(0)};
            4'd2:    r = '{c0: coef_t'(0),       c1: coef_t'(16'h0800)};
            4'd3:    r = '{c0: coef_t'(16'h0400), c1: coef_t'(16'h0400)};
            4'd4:    r = '{c0: coef_t'(16'h1000), c1: -coef_t'(16'h0800)};
            4'd5:    r = '{c0: coef_t'(16'h0E00), c1: -coef_t'(16'h0600)};
            4'd6:    r = '{c0: coef_t'(16'h0C00), c1: -coef_t'(16'h0400)};
            4'd7:    r = '{c0: coef_t'(16'h1200), c1: -coef_t'(16'h0A00)};
            4'd8:    r = '{c0: coef_t'(16'h1068), c1: -coef_t'(16'h08C8)};
            4'd9:    r = '{c0: coef_t'(16'h12C0), c1: -coef_t'(16'h08FC)};
            4'd10:   r = '{c0: coef_t'(16'h1400), c1: -coef_t'(16'h0C00)};
            4'd11:   r = '{c0: coef_t'(16'h0800), c1: -coef_t'(16'h0800)};
            4'd12:   r = '{c0: coef_t'(16'h0400), c1: -coef_t'(16'h0400)};
            4'd13:   r = '{c0: -coef_t'(16'h0400), c1: coef_t'(16'h0400)};
            4'd14:   r = '{c0: -coef_t'(16'h0400), c1: coef_t'(0)};
            default: r = '{c0: -coef_t'(16'h0800), c1: coef_t'(0)};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/afd_mac.sv =====
// Shared multiply-accumulate unit with rounding-down shift and saturation.
`default_nettype none

module afd_mac (
    input  wire                      aclk,
    input  wire afd_pkg::mac_ctrl_t  ctrl,
    input  wire afd_pkg::sample_t    prev_sample,
    input  wire afd_pkg::sample_t    older_sample,
    input  wire afd_pkg::coef_pair_t coef,
    input  wire afd_pkg::acc_t       code_term,
    output afd_pkg::sample_t         sample
);

    afd_pkg::acc_t    acc_reg;
    afd_pkg::sample_t mul_a;
    afd_pkg::coef_t   mul_b;
    logic signed [afd_pkg::SAMPLE_W+afd_pkg::COEF_W-1:0] prod;
    afd_pkg::acc_t    prod_ext;
    afd_pkg::acc_t    sum;
    afd_pkg::acc_t    shifted;

    always_comb begin
        mul_a    = ctrl.older_sel ? older_sample : prev_sample;
        mul_b    = ctrl.older_sel ? coef.c1 : coef.c0;
        prod     = mul_a * mul_b;
        prod_ext = afd_pkg::acc_t'(prod);
        sum      = acc_reg + prod_ext;
        shifted  = sum >>> afd_pkg::FRAC_W;
        if (shifted > afd_pkg::SAT_MAX) begin
            sample = afd_pkg::sample_t'(afd_pkg::SAT_MAX);
        end else if (shifted < afd_pkg::SAT_MIN) begin
            sample = afd_pkg::sample_t'(afd_pkg::SAT_MIN);
        end else begin
            sample = shifted[afd_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg <= code_term + prod_ext;
        end
    end

endmodule

`default_nettype wire

// ===== src/adpcm_frame_decoder_unit.sv =====
// Top level of the ADPCM frame decoder: sequencer, frame state and output register.
`default_nettype none

// Channel    | Dir | Ports                                   | Moves
// -----------+-----+-----------------------------------------+-------------------------
// cfg        | in  | cfg_valid, cfg_ready, cfg_small_frame_mode | frame mode register
// s (input)  | in  | s_valid, s_ready, s_stream_byte         | one stream byte
// m (output) | out | m_valid, m_ready, m_pcm_sample, m_last_of_byte | one decoded sample
//
// Sequencing: a header byte produces no output. A data byte holds N = 2 samples
//   (4-bit codes) or 4 samples (2-bit codes). The single shared
//   multiplier needs two passes per sample (prev*c0, then older*c1).
// s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) clears mode, frame position, header and history.
// A full output register with m_ready low holds the sequencer in its second pass.
module adpcm_frame_decoder_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_small_frame_mode,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_stream_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic signed [15:0] m_pcm_sample,
    output logic        m_last_of_byte
);

    afd_pkg::state_t   state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [3:0]        pos_reg, pos_next;
    logic [3:0]        scale_shift_reg, scale_shift_next;
    logic [3:0]        pred_reg, pred_next;
    afd_pkg::sample_t  prev_reg, prev_next;
    afd_pkg::sample_t  older_reg, older_next;
    logic [7:0]        data_reg, data_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    afd_pkg::sample_t  m_sample_reg, m_sample_next;
    logic              m_last_reg, m_last_next;

    afd_pkg::mac_ctrl_t  mac_ctrl;
    afd_pkg::coef_pair_t coef;
    afd_pkg::sample_t    mac_sample;
    afd_pkg::acc_t       code_term;
    logic signed [3:0]   code_v;
    logic [4:0]          shamt;
    logic [3:0]          pos_inc;
    logic [3:0]          frame_len;
    logic [1:0]          last_idx;
    logic                is_last;
    logic                out_free;

    // code of the current sample sits in the top bits of data_reg
    always_comb begin
        code_v    = mode_reg ? {{2{data_reg[7]}}, data_reg[7:6]} : data_reg[7:4];
        shamt     = {1'b0, scale_shift_reg}
                  + (mode_reg ? afd_pkg::CODE_K_SMALL : afd_pkg::CODE_K_LARGE);
        code_term = afd_pkg::acc_t'(code_v) <<< shamt;
        coef      = afd_pkg::pred_coef(pred_reg);
    end

    afd_mac u_mac (
        .aclk         (aclk),
        .ctrl         (mac_ctrl),
        .prev_sample  (prev_reg),
        .older_sample (older_reg),
        .coef         (coef),
        .code_term    (code_term),
        .sample       (mac_sample)
    );

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        scale_shift_next = scale_shift_reg;
        pred_next        = pred_reg;
        prev_next        = prev_reg;
        older_next       = older_reg;
        data_next        = data_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_sample_next    = m_sample_reg;
        m_last_next      = m_last_reg;

        cfg_ready = 1'b1;
        s_ready   = 1'b0;
        mac_ctrl  = '{load: 1'b0, older_sel: 1'b0};

        frame_len = mode_reg ? afd_pkg::FRAME_LEN_SMALL : afd_pkg::FRAME_LEN_LARGE;
        last_idx  = mode_reg ? afd_pkg::LAST_IDX_SMALL : afd_pkg::LAST_IDX_LARGE;
        pos_inc   = pos_reg + 4'd1;
        is_last   = (cnt_reg == last_idx);
        out_free  = ~m_valid_reg | m_ready;

        if (cfg_valid) begin
            mode_next = cfg_small_frame_mode;
        end

        unique case (state_reg)
            afd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (pos_reg == 4'd0) begin
                        // header: scale shift and predictor pair, no output
                        scale_shift_next = s_stream_byte[7:4];
                        pred_next        = s_stream_byte[3:0];
                        pos_next         = 4'd1;
                    end else begin
                        data_next  = s_stream_byte;
                        cnt_next   = 2'd0;
                        state_next = afd_pkg::ST_TERM0;
                        pos_next   = (pos_inc >= frame_len) ? 4'd0 : pos_inc;
                    end
                end
            end
            afd_pkg::ST_TERM0: begin
                mac_ctrl   = '{load: 1'b1, older_sel: 1'b0};
                state_next = afd_pkg::ST_TERM1;
            end
            afd_pkg::ST_TERM1: begin
                mac_ctrl = '{load: 1'b0, older_sel: 1'b1};
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = mac_sample;
                    m_last_next   = is_last;
                    older_next    = prev_reg;
                    prev_next     = mac_sample;
                    data_next     = mode_reg ? {data_reg[5:0], 2'b00}
                                             : {data_reg[3:0], 4'b0000};
                    cnt_next      = cnt_reg + 2'd1;
                    state_next    = is_last ? afd_pkg::ST_IDLE : afd_pkg::ST_TERM0;
                end
            end
            default: begin
                state_next = afd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= afd_pkg::ST_IDLE;
            mode_reg        <= 1'b0;
            pos_reg         <= 4'd0;
            scale_shift_reg <= 4'd0;
            pred_reg        <= 4'd0;
            prev_reg        <= '0;
            older_reg       <= '0;
            cnt_reg         <= 2'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            scale_shift_reg <= scale_shift_next;
            pred_reg        <= pred_next;
            prev_reg        <= prev_next;
            older_reg       <= older_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        m_sample_reg <= m_sample_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pcm_sample   = m_sample_reg;
    assign m_last_of_byte = m_last_reg;

endmodule

`default_nettype wire

// ===== tb/tb_adpcm_frame_decoder_unit.sv =====
// Self-checking testbench for adpcm_frame_decoder_unit: directed and random byte streams.
module tb_adpcm_frame_decoder_unit;

    localparam int HALF_PERIOD = 10;
    localparam int IDLE_PCT    = 14;      // percent of cycles a side idles
    localparam int SETTLE_GAP  = 16;      // cycles after the last sample before a cfg write
    localparam int CYCLE_LIMIT = 200000;  // worst legal run is a small fraction of this
    localparam int RAND_PHASES = 7;
    localparam int PHASE_BYTES = 21;
    localparam int QUIET_PHASE = 3;       // phase run with no idling on either side

    // predictor pair table, coefficient on the previous and on the older sample
    localparam int PREV_COEF [16] = '{
        'h0000, 'h0800, 'h0000, 'h0400, 'h1000, 'h0E00, 'h0C00, 'h1200,
        'h1068, 'h12C0, 'h1400, 'h0800, 'h0400, -'h0400, -'h0400, -'h0800
    };
    localparam int OLDER_COEF [16] = '{
        'h0000, 'h0000, 'h0800, 'h0400, -'h0800, -'h0600, -'h0400, -'h0A00,
        -'h08C8, -'h08FC, -'h0C00, -'h0800, -'h0400, 'h0400, 'h0000, 'h0000
    };

    typedef struct {
        afd_pkg::sample_t pcm;
        bit               last;
    } pcm_beat_t;

    // Tracks frame position, header fields and sample history; queues the
    // samples each accepted byte must produce and checks them in order.
    class pcm_scoreboard;
        bit               small_mode;
        logic [3:0]       frame_pos;
        logic [3:0]       shift;
        logic [3:0]       pred_sel;
        afd_pkg::sample_t prev_s;
        afd_pkg::sample_t older_s;
        pcm_beat_t        pcm_expect_q[$];
        int               errors;

        function new();
            small_mode = 1'b0;
            frame_pos  = '0;
            shift      = '0;
            pred_sel   = '0;
            prev_s     = '0;
            older_s    = '0;
            errors     = 0;
        endfunction

        function void set_mode(bit m);
            small_mode = m;
        endfunction

        function bit at_header();
            return frame_pos == 4'd0;
        endfunction

        function int outstanding();
            return pcm_expect_q.size();
        endfunction

        // one multiply-accumulate sample, floor shift and saturation
        function afd_pkg::sample_t next_sample(longint code_scaled);
            longint acc;
            longint s;
            acc = (longint'(1) << shift) * code_scaled
                + longint'(prev_s) * PREV_COEF[pred_sel]
                + longint'(older_s) * OLDER_COEF[pred_sel];
            s = acc >>> afd_pkg::FRAC_W;
            if (s > 32767)
                s = 32767;
            else if (s < -32768)
                s = -32768;
            older_s = prev_s;
            prev_s  = afd_pkg::sample_t'(s);
            return afd_pkg::sample_t'(s);
        endfunction

        function void note_byte(logic [7:0] b);
            int               n;
            logic signed [1:0] c2;
            logic signed [3:0] c4;
            longint           code;
            pcm_beat_t        beat;
            if (frame_pos == 4'd0) begin
                shift     = b[7:4];
                pred_sel  = b[3:0];
                frame_pos = 4'd1;
                return;
            end
            n = small_mode ? 4 : 2;
            for (int k = 0; k < n; k++) begin
                if (small_mode) begin
                    c2   = b[7-2*k -: 2];
                    code = longint'(c2) * 8192;
                end else begin
                    c4   = b[7-4*k -: 4];
                    code = longint'(c4) * 2048;
                end
                beat.pcm  = next_sample(code);
                beat.last = (k == n - 1);
                pcm_expect_q.push_back(beat);
            end
            frame_pos = frame_pos + 4'd1;
            if (frame_pos >= (small_mode ? afd_pkg::FRAME_LEN_SMALL
                                         : afd_pkg::FRAME_LEN_LARGE))
                frame_pos = 4'd0;
        endfunction

        function void check_sample(afd_pkg::sample_t pcm, bit last);
            pcm_beat_t want;
            if (pcm_expect_q.size() == 0) begin
                $display("%0t: unexpected sample %0d last %0b", $time, pcm, last);
                errors++;
                return;
            end
            want = pcm_expect_q.pop_front();
            if (pcm !== want.pcm) begin
                $display("%0t: pcm_sample expected %0d actual %0d", $time, want.pcm, pcm);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_byte expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_small_frame_mode = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_stream_byte = 8'h00;
    logic             m_valid;
    logic             m_ready = 1'b0;
    afd_pkg::sample_t m_pcm_sample;
    logic             m_last_of_byte;

    bit             no_idle = 1'b0;  // set for the quiet phase: nobody stalls
    int             cycles = 0;
    pcm_scoreboard  sb = new();

    always #HALF_PERIOD aclk = ~aclk;

    adpcm_frame_decoder_unit i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_small_frame_mode (cfg_small_frame_mode),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_stream_byte        (s_stream_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_pcm_sample         (m_pcm_sample),
        .m_last_of_byte       (m_last_of_byte)
    );

    // Receiver back-pressure: random stalls except during the quiet phase.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor: every output transaction is checked against the oldest
    // expected sample. Values read here are the ones present at the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_sample(m_pcm_sample, m_last_of_byte);
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d samples still expected", $time, sb.outstanding());
            $display("FAIL adpcm_frame_decoder_unit");
            $finish;
        end
    end

    // Push one stream byte. A random idle gap drops valid first; otherwise
    // valid stays high straight into the next transaction.
    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        sb.note_byte(b);
    endtask

    // Sender drops valid and holds off until every expected sample is out, then
    // waits out SETTLE_GAP before anything else happens.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    // Mode register write; only called with the block idle.
    task automatic write_mode(input bit m);
        cfg_valid            <= 1'b1;
        cfg_small_frame_mode <= m;
        do
            @(posedge aclk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_list(input logic [7:0] list[$]);
        foreach (list[i])
            send_byte(list[i]);
    endtask

    initial begin
        logic [7:0] rand_b;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Large frames: header with shift 15 (full 2^15 scale) and predictor 8,
        // then code extremes +7/-8, mixed nibbles and all-ones/all-zeros.
        send_list('{8'hF8, 8'h77, 8'h77, 8'h88, 8'h88, 8'h80, 8'h08, 8'hFF, 8'h00});
        settle();

        // Small frames: shift 0 with the last predictor pair, 2-bit code extremes.
        write_mode(1'b1);
        send_list('{8'h0F, 8'h55, 8'hAA, 8'hFF, 8'h00});
        settle();

        // Mode switch inside a large frame: position 6 when switching to small,
        // so the next byte decodes as 2-bit codes and the frame closes past 5.
        write_mode(1'b0);
        send_list('{8'h3A, 8'h19, 8'hE7, 8'h42, 8'hBD, 8'h5A});
        settle();
        write_mode(1'b1);
        send_list('{8'hC3, 8'hFF, 8'h6C});
        settle();

        // Random phases. Mode changes land at whatever frame position the
        // previous phase left, so both mid-frame directions get exercised.
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_mode(p < 2 ? bit'(p) : bit'($urandom_range(0, 1)));
            no_idle = (p == QUIET_PHASE);
            for (int i = 0; i < PHASE_BYTES; i++) begin
                rand_b = 8'($urandom_range(0, 255));
                // half the headers are forced to a low shift so samples stay off the rails
                if (sb.at_header() && $urandom_range(0, 1) == 1)
                    rand_b[7] = 1'b0;
                send_byte(rand_b);
            end
            no_idle = 1'b0;
            settle();
        end

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS adpcm_frame_decoder_unit");
        end else begin
            $display("FAIL adpcm_frame_decoder_unit");
        end
        $finish;
    end

endmodule
